>>> sv/cc_pkg.sv
package cc_pkg;

  // Width of one center coordinate on the result ports.
  localparam int OUT_W = 32;

  // Quotient bits developed by the divider; one spare bit above the output
  // range is enough to tell a saturating quotient from a fitting one.
  localparam int QB = OUT_W + 1;

  localparam logic [OUT_W-1:0] SAT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] SAT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

  // Control that travels with each beat down the pipeline.
  typedef struct packed {
    logic vld;
    logic degen;
  } tag_t;

endpackage

>>> sv/cc_mulw.sv
// Signed multiply of a narrow operand by a wide one, split into two partial
// products on the wide operand and summed in a second register stage.
module cc_mulw #(
  parameter int AW = 25,
  parameter int BW = 51
) (
  input  logic                    clk_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic signed [BW-1:0]    b_i,
  output logic signed [AW+BW-1:0] p_o
);

  localparam int HW = BW / 2;
  localparam int LW = BW - HW;
  localparam int PW = AW + BW;

  logic signed [AW+LW:0]   pl_q;
  logic signed [AW+HW-1:0] ph_q;
  logic signed [PW-1:0]    p_q;

  // Partial products: low half taken as unsigned, high half as signed.
  always_ff @(posedge clk_i) begin
    pl_q <= a_i * $signed({1'b0, b_i[LW-1:0]});
    ph_q <= a_i * $signed(b_i[BW-1:LW]);
  end

  // Recombine the partial products.
  always_ff @(posedge clk_i) begin
    p_q <= (PW'(ph_q) <<< LW) + PW'(pl_q);
  end

  assign p_o = p_q;

endmodule

>>> sv/cc_div.sv
// Pipelined restoring divider: signed truncating quotient, saturated to the
// output range. One quotient bit is resolved in each bit stage.
module cc_div #(
  parameter int NW = 77,
  parameter int DW = 52
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  cc_pkg::tag_t                tag_i,
  input  logic signed [NW-1:0]        num_i,
  input  logic signed [DW-1:0]        den_i,
  output cc_pkg::tag_t                tag_o,
  output logic [cc_pkg::OUT_W-1:0]    quo_o,
  output logic                        ovf_o
);

  localparam int QB = cc_pkg::QB;
  localparam int OW = cc_pkg::OUT_W;
  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  // Magnitude stage.
  cc_pkg::tag_t  tag_a_q;
  logic [NW-1:0] an_q;
  logic [DW-1:0] ad_a_q;
  logic          neg_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_a_q <= '0;
    end else begin
      tag_a_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    an_q    <= num_i[NW-1] ? NW'(-num_i) : NW'(num_i);
    ad_a_q  <= den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
    neg_a_q <= num_i[NW-1] ^ den_i[DW-1];
  end

  // Range stage and the bit stages share these arrays; entry 0 is the range stage.
  cc_pkg::tag_t  tag_q [QB+1];
  logic [NW-1:0] rem_q [QB+1];
  logic [DW-1:0] ad_q  [QB+1];
  logic [QB-1:0] q_q   [QB+1];
  logic          neg_q [QB+1];
  logic          big_q [QB+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q[0] <= '0;
    end else begin
      tag_q[0] <= tag_a_q;
    end
  end

  // A quotient of 2**QB or more saturates whatever its sign.
  always_ff @(posedge clk_i) begin
    rem_q[0] <= an_q;
    ad_q[0]  <= ad_a_q;
    q_q[0]   <= '0;
    neg_q[0] <= neg_a_q;
    big_q[0] <= CW'(an_q) >= (CW'(ad_a_q) << QB);
  end

  for (genvar k = 0; k < QB; k++) begin : g_bit
    localparam int S = QB - 1 - k;
    logic [CW:0] trial;

    // Trial subtraction of the shifted divisor.
    assign trial = (CW+1)'(rem_q[k]) - ((CW+1)'(ad_q[k]) << S);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k+1] <= '0;
      end else begin
        tag_q[k+1] <= tag_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= trial[CW] ? rem_q[k] : trial[NW-1:0];
      ad_q[k+1]  <= ad_q[k];
      q_q[k+1]   <= {q_q[k][QB-2:0], ~trial[CW]};
      neg_q[k+1] <= neg_q[k];
      big_q[k+1] <= big_q[k];
    end
  end

  // Sign and saturation stage.
  logic [QB-1:0] qf;
  logic          negf;
  logic          bigf;
  logic [OW-1:0] quo_d;
  logic          ovf_d;
  cc_pkg::tag_t  tag_f_q;
  logic [OW-1:0] quo_q;
  logic          ovf_q;

  assign qf   = q_q[QB];
  assign negf = neg_q[QB];
  assign bigf = big_q[QB];

  always_comb begin
    if (negf) begin
      if (bigf || qf > QB'({1'b1, {(OW-1){1'b0}}})) begin
        quo_d = cc_pkg::SAT_MIN;
        ovf_d = 1'b1;
      end else begin
        quo_d = OW'(-qf);
        ovf_d = 1'b0;
      end
    end else begin
      if (bigf || qf[QB-1] || qf[OW-1]) begin
        quo_d = cc_pkg::SAT_MAX;
        ovf_d = 1'b1;
      end else begin
        quo_d = qf[OW-1:0];
        ovf_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_f_q <= '0;
    end else begin
      tag_f_q <= tag_q[QB];
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    ovf_q <= ovf_d;
  end

  assign tag_o = tag_f_q;
  assign quo_o = quo_q;
  assign ovf_o = ovf_q;

endmodule

>>> sv/circumcenter_three_points_top.sv
// Circumcenter of three planar points.
// Channels: an input beat is taken at a rising edge where start is high and
// busy is low; it carries the three points as signed fixed-point coordinates
// of COORD_WIDTH bits. busy stays low, so a new beat may come every cycle.
// Each result beat appears on the result ports for exactly one cycle with
// done_o high: center_x_o and center_y_o with the same fraction bits as the
// inputs, degenerate_o for collinear or coincident points (center zero) and
// overflow_o when a coordinate was clamped to the 32-bit range.
// Path: an accepted beat passes seven stages of bisector and Cramer
// arithmetic, then a 36-stage divider that develops one quotient bit in each
// of its bit stages, then the result register, which drives done_o.
// Throughput: one beat per cycle, set by the fully pipelined divider.
// Results leave in the order their beats were taken.
// Reset clears all valid bits; beats in flight are dropped and no strobe
// follows. The receiver cannot hold results off, so nothing ever stalls.
module circumcenter_three_points_top #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] start_x_i,
  input  logic signed [COORD_WIDTH-1:0] start_y_i,
  input  logic signed [COORD_WIDTH-1:0] mid_x_i,
  input  logic signed [COORD_WIDTH-1:0] mid_y_i,
  input  logic signed [COORD_WIDTH-1:0] end_x_i,
  input  logic signed [COORD_WIDTH-1:0] end_y_i,
  output logic                          done_o,
  output logic signed [31:0]            center_x_o,
  output logic signed [31:0]            center_y_o,
  output logic                          degenerate_o,
  output logic                          overflow_o
);

  localparam int W  = COORD_WIDTH;
  localparam int DW = W + 1;
  localparam int PW = 2 * W + 2;
  localparam int CW = 2 * W + 3;
  localparam int MW = DW + CW;
  localparam int NW = MW + 1;
  localparam int TW = CW + 1;
  localparam int OW = cc_pkg::OUT_W;

  assign busy = 1'b0;

  // Valid bits of the arithmetic stages.
  logic [6:0] v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[5:0], start & ~busy};
    end
  end

  // Stage 0: capture the points.
  logic signed [W-1:0] x1_q, y1_q, x2_q, y2_q, x3_q, y3_q;

  always_ff @(posedge clk_i) begin
    x1_q <= start_x_i;
    y1_q <= start_y_i;
    x2_q <= mid_x_i;
    y2_q <= mid_y_i;
    x3_q <= end_x_i;
    y3_q <= end_y_i;
  end

  // Stage 1: edge vectors and coordinate sums.
  logic signed [DW-1:0] a1_q, b1_q, d1_q, e1_q, s1_q, t1_q, s2_q, t2_q;

  always_ff @(posedge clk_i) begin
    a1_q <= DW'(x2_q) - DW'(x1_q);
    b1_q <= DW'(y2_q) - DW'(y1_q);
    d1_q <= DW'(x3_q) - DW'(x2_q);
    e1_q <= DW'(y3_q) - DW'(y2_q);
    s1_q <= DW'(x2_q) + DW'(x1_q);
    t1_q <= DW'(y2_q) + DW'(y1_q);
    s2_q <= DW'(x3_q) + DW'(x2_q);
    t2_q <= DW'(y3_q) + DW'(y2_q);
  end

  // Stage 2: the six narrow products.
  logic signed [PW-1:0] pas_q, pbt_q, pds_q, pet_q, pbd_q, pea_q;
  logic signed [DW-1:0] a2_q, b2_q, d2_q, e2_q;

  always_ff @(posedge clk_i) begin
    pas_q <= a1_q * s1_q;
    pbt_q <= b1_q * t1_q;
    pds_q <= d1_q * s2_q;
    pet_q <= e1_q * t2_q;
    pbd_q <= b1_q * d1_q;
    pea_q <= e1_q * a1_q;
    a2_q  <= a1_q;
    b2_q  <= b1_q;
    d2_q  <= d1_q;
    e2_q  <= e1_q;
  end

  // Stage 3: right-hand sides and the shared determinant.
  logic signed [CW-1:0] c3_q, f3_q, det3_q;
  logic signed [DW-1:0] a3_q, b3_q, d3_q, e3_q;

  always_ff @(posedge clk_i) begin
    c3_q   <= CW'(pas_q) + CW'(pbt_q);
    f3_q   <= CW'(pds_q) + CW'(pet_q);
    det3_q <= CW'(pbd_q) - CW'(pea_q);
    a3_q   <= a2_q;
    b3_q   <= b2_q;
    d3_q   <= d2_q;
    e3_q   <= e2_q;
  end

  // Stages 4 and 5: the four wide products of Cramer's rule.
  logic signed [MW-1:0] pbf, pce, pcd, paf;
  logic signed [CW-1:0] det4_q, det5_q;

  cc_mulw #(.AW(DW), .BW(CW)) u_mul_bf (.clk_i, .a_i(b3_q), .b_i(f3_q), .p_o(pbf));
  cc_mulw #(.AW(DW), .BW(CW)) u_mul_ce (.clk_i, .a_i(e3_q), .b_i(c3_q), .p_o(pce));
  cc_mulw #(.AW(DW), .BW(CW)) u_mul_cd (.clk_i, .a_i(d3_q), .b_i(c3_q), .p_o(pcd));
  cc_mulw #(.AW(DW), .BW(CW)) u_mul_af (.clk_i, .a_i(a3_q), .b_i(f3_q), .p_o(paf));

  always_ff @(posedge clk_i) begin
    det4_q <= det3_q;
    det5_q <= det4_q;
  end

  // Stage 6: numerators, doubled determinant and the collinear check.
  logic signed [NW-1:0] numx_q, numy_q;
  logic signed [TW-1:0] det6_q;
  logic                 degen6_q;
  cc_pkg::tag_t         tag6;

  always_ff @(posedge clk_i) begin
    numx_q   <= NW'(pbf) - NW'(pce);
    numy_q   <= NW'(pcd) - NW'(paf);
    det6_q   <= TW'(det5_q) <<< 1;
    degen6_q <= (det5_q == '0);
  end

  assign tag6.vld   = v_q[6];
  assign tag6.degen = degen6_q;

  // Two dividers share the determinant.
  cc_pkg::tag_t  tagx, tagy;
  logic [OW-1:0] qx, qy;
  logic          ovx, ovy;

  cc_div #(.NW(NW), .DW(TW)) u_div_x (
    .clk_i, .rst_ni, .tag_i(tag6), .num_i(numx_q), .den_i(det6_q),
    .tag_o(tagx), .quo_o(qx), .ovf_o(ovx)
  );

  cc_div #(.NW(NW), .DW(TW)) u_div_y (
    .clk_i, .rst_ni, .tag_i(tag6), .num_i(numy_q), .den_i(det6_q),
    .tag_o(tagy), .quo_o(qy), .ovf_o(ovy)
  );

  // Result register: a collinear beat reports a zero center.
  logic          done_q;
  logic [OW-1:0] cx_q, cy_q;
  logic          dg_q, ov_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= tagx.vld & tagy.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    cx_q <= tagx.degen ? '0 : qx;
    cy_q <= tagx.degen ? '0 : qy;
    dg_q <= tagx.degen;
    ov_q <= ~tagx.degen & (ovx | ovy);
  end

  assign done_o       = done_q;
  assign center_x_o   = cx_q;
  assign center_y_o   = cy_q;
  assign degenerate_o = dg_q;
  assign overflow_o   = ov_q;

  // A collinear beat reports a zero center and no clamping.
  a_degen_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && degenerate_o |-> center_x_o == '0 && center_y_o == '0 && !overflow_o)
    else $error("degenerate result with nonzero center");

  // A clamped beat carries at least one coordinate at a range limit.
  a_ovf_sat : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && overflow_o |->
      center_x_o == cc_pkg::SAT_MAX || center_x_o == cc_pkg::SAT_MIN ||
      center_y_o == cc_pkg::SAT_MAX || center_y_o == cc_pkg::SAT_MIN)
    else $error("overflow without a saturated coordinate");

  // Both dividers stay in lock step.
  a_div_lock : assert property (@(posedge clk_i) disable iff (!rst_ni)
    tagx.vld == tagy.vld)
    else $error("divider pipelines out of step");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  localparam int CW = 24;
  localparam int N_RANDOM = 400;
  localparam int FLUSH_CYCLES = 60;

  typedef struct {
    logic signed [CW-1:0] x1, y1, x2, y2, x3, y3;
  } triple_t;

  typedef struct {
    logic signed [31:0] cx, cy;
    logic               degen, ovf;
  } center_t;

  // Directed row: points, plus a typed expectation where it is obvious.
  typedef struct {
    triple_t pts;
    bit      fixed;
    center_t want;
  } row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  logic signed [CW-1:0] start_x_i, start_y_i, mid_x_i, mid_y_i, end_x_i, end_y_i;
  logic                 done_o;
  logic signed [31:0]   center_x_o, center_y_o;
  logic                 degenerate_o, overflow_o;

  center_t centers_due[$];
  int      n_errors;
  int      n_results;
  int      n_beats;
  int      n_degen;
  int      n_ovf;
  bit      quiet_phase;

  circumcenter_three_points_top #(.COORD_WIDTH(CW)) u_dut (
    .clk_i, .rst_ni, .start, .busy,
    .start_x_i, .start_y_i, .mid_x_i, .mid_y_i, .end_x_i, .end_y_i,
    .done_o, .center_x_o, .center_y_o, .degenerate_o, .overflow_o
  );

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Truncating signed divide, clamped to 32 bits.
  function automatic logic signed [31:0] quot_clamped(
    input logic signed [127:0] num, input logic signed [127:0] den, inout logic ovf);
    logic signed [127:0] q;
    begin
      q = num / den;
      if (q > 128'sd2147483647) begin
        ovf = 1'b1;
        return 32'h7fffffff;
      end
      if (q < -128'sd2147483648) begin
        ovf = 1'b1;
        return 32'h80000000;
      end
      return q[31:0];
    end
  endfunction

  // Circumcenter from the perpendicular bisectors, Cramer's rule.
  function automatic center_t circumcenter(input triple_t p);
    logic signed [127:0] x1, y1, x2, y2, x3, y3, a, b, d, e, c, f, det;
    center_t r;
    begin
      x1 = p.x1; y1 = p.y1; x2 = p.x2; y2 = p.y2; x3 = p.x3; y3 = p.y3;
      a = x2 - x1; b = y2 - y1;
      d = x3 - x2; e = y3 - y2;
      c = a * (x2 + x1) + b * (y2 + y1);
      f = d * (x3 + x2) + e * (y3 + y2);
      det = b * d - e * a;
      r.ovf = 1'b0;
      if (det == 0) begin
        r.cx = '0; r.cy = '0; r.degen = 1'b1;
        return r;
      end
      det = det + det;
      r.degen = 1'b0;
      r.cx = quot_clamped(b * f - c * e, det, r.ovf);
      r.cy = quot_clamped(c * d - a * f, det, r.ovf);
      return r;
    end
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    begin
      n_errors++;
      $display("ERROR %0t: %s got %0d expected %0d", $time, what, got, want);
    end
  endtask

  // Check each result beat against the oldest expected center.
  always @(posedge clk_i) begin
    center_t w;
    if (rst_ni && done_o) begin
      n_results++;
      if (centers_due.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = centers_due.pop_front();
        if (center_x_o !== w.cx) report_mismatch("center_x", center_x_o, w.cx);
        if (center_y_o !== w.cy) report_mismatch("center_y", center_y_o, w.cy);
        if (degenerate_o !== w.degen) report_mismatch("degenerate", degenerate_o, w.degen);
        if (overflow_o !== w.ovf) report_mismatch("overflow", overflow_o, w.ovf);
        if (w.degen) n_degen++;
        if (w.ovf) n_ovf++;
      end
    end
  end

  function automatic logic signed [CW-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 24'sh7fffff : 24'sh800000;
      1: return $signed(24'($urandom_range(0, 63))) - 24'sd32;
      2: return $signed(24'($urandom_range(0, 8191))) - 24'sd4096;
      default: return 24'($urandom);
    endcase
  endfunction

  function automatic triple_t rand_triple();
    triple_t t;
    int k;
    begin
      t.x1 = rand_coord(); t.y1 = rand_coord();
      t.x2 = rand_coord(); t.y2 = rand_coord();
      t.x3 = rand_coord(); t.y3 = rand_coord();
      // Some triples are forced collinear or coincident.
      case ($urandom_range(0, 9))
        0: begin t.x3 = t.x2; t.y3 = t.y2; end
        1: begin
          k = $urandom_range(0, 3);
          t.x1 = $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
          t.y1 = $signed(24'($urandom_range(0, 2000))) - 24'sd1000;
          t.x2 = t.x1 + 24'sd37; t.y2 = t.y1 + 24'sd11;
          t.x3 = t.x1 + 24'(37 * k); t.y3 = t.y1 + 24'(11 * k);
        end
        default: ;
      endcase
      return t;
    end
  endfunction

  // Drive one beat, idling at random before it, and wait for acceptance.
  task automatic send_beat(input triple_t t, input center_t want);
    begin
      while (!quiet_phase && $urandom_range(0, 99) < 22) begin
        start <= 1'b0;
        @(posedge clk_i);
      end
      start     <= 1'b1;
      start_x_i <= t.x1; start_y_i <= t.y1;
      mid_x_i   <= t.x2; mid_y_i   <= t.y2;
      end_x_i   <= t.x3; end_y_i   <= t.y3;
      @(posedge clk_i);
      while (busy) @(posedge clk_i);
      centers_due.push_back(want);
      n_beats++;
    end
  endtask

  function automatic row_t mk(input int x1, y1, x2, y2, x3, y3,
                              input bit fixed = 0, input int cx = 0, cy = 0,
                              input bit dg = 0, input bit ov = 0);
    row_t r;
    begin
      r.pts.x1 = CW'(x1); r.pts.y1 = CW'(y1); r.pts.x2 = CW'(x2);
      r.pts.y2 = CW'(y2); r.pts.x3 = CW'(x3); r.pts.y3 = CW'(y3);
      r.fixed = fixed;
      r.want.cx = cx; r.want.cy = cy; r.want.degen = dg; r.want.ovf = ov;
      return r;
    end
  endfunction

  localparam int MAXC = 8388607;
  localparam int MINC = -8388608;

  initial begin
    row_t rows[$];
    center_t w;
    int wait_cnt;
    n_errors = 0; n_results = 0; n_beats = 0; n_degen = 0; n_ovf = 0;
    quiet_phase = 1'b0;
    rst_ni = 1'b0;
    start = 1'b0;
    start_x_i = '0; start_y_i = '0; mid_x_i = '0;
    mid_y_i = '0; end_x_i = '0; end_y_i = '0;

    // Directed table: degenerate cases, extremes, overflow, plain triangles.
    rows.push_back(mk(0, 0, 0, 0, 0, 0, 1, 0, 0, 1, 0));
    rows.push_back(mk(MAXC, MAXC, MAXC, MAXC, MAXC, MAXC, 1, 0, 0, 1, 0));
    rows.push_back(mk(MINC, MINC, MINC, MINC, MINC, MINC, 1, 0, 0, 1, 0));
    rows.push_back(mk(0, 0, 256, 256, 512, 512, 1, 0, 0, 1, 0));
    rows.push_back(mk(MINC, MINC, 0, 0, MAXC, MAXC));
    rows.push_back(mk(5, 7, 5, 7, 100, -3, 1, 0, 0, 1, 0));
    rows.push_back(mk(0, 0, 512, 0, 0, 512, 1, 256, 256, 0, 0));
    rows.push_back(mk(-256, 0, 256, 0, 0, 256, 1, 0, 0, 0, 0));
    rows.push_back(mk(MINC, MINC, MAXC, MINC, MINC, MAXC));
    rows.push_back(mk(MAXC, MAXC, MINC, MAXC, MAXC, MINC));
    rows.push_back(mk(MINC, 0, MAXC, 0, 0, MAXC));
    rows.push_back(mk(MINC, MINC, MAXC, MAXC, MAXC, MAXC - 1));
    rows.push_back(mk(MINC, MINC, MAXC, MAXC, MAXC - 1, MAXC));
    rows.push_back(mk(MINC, MAXC, MAXC, MINC, MINC + 1, MAXC));
    rows.push_back(mk(0, 0, 1, 0, MAXC, 1));
    rows.push_back(mk(0, 0, 1, 0, MINC, -1));
    rows.push_back(mk(-1, -1, 1, 2, 3, -5));
    rows.push_back(mk(1000, -2000, -3000, 4000, 5000, 6000));
    rows.push_back(mk(-1, 0, 0, -1, 1, 1));

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      w = rows[i].fixed ? rows[i].want : circumcenter(rows[i].pts);
      send_beat(rows[i].pts, w);
    end

    // Random triples, with a stretch of back-to-back beats in the middle.
    for (int i = 0; i < N_RANDOM; i++) begin
      triple_t t;
      quiet_phase = (i >= 150 && i < 250);
      t = rand_triple();
      send_beat(t, circumcenter(t));
    end
    start <= 1'b0;

    wait_cnt = 0;
    while (centers_due.size() != 0 && wait_cnt < 1000) begin
      @(posedge clk_i);
      wait_cnt++;
    end
    repeat (FLUSH_CYCLES) @(posedge clk_i);

    $display("Run covered %0d beats and %0d results (%0d degenerate, %0d saturated).",
             n_beats, n_results, n_degen, n_ovf);
    if (n_errors == 0 && centers_due.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches, %0d results missing", n_errors, centers_due.size());
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

endmodule

>>> files.f
sv/cc_pkg.sv
sv/cc_mulw.sv
sv/cc_div.sv
sv/circumcenter_three_points_top.sv
bench/tb.sv
